/* sv/assert_macros.svh */
// assertion macros shared by the cache rtl
// every macro samples on i_clk and is held off while i_rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every edge
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/lkv_pkg.sv */
// shared constants and types for the lru key-value cache
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package lkv_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int CAP_W      = 5;
    localparam int ADDR_W     = 3;

    localparam logic [ADDR_W-1:0] ADDR_CAPACITY = ADDR_W'(0);
    localparam logic [CAP_W-1:0]  CAP_RESET     = CAP_W'(16);

    localparam logic REQ_LOOKUP = 1'b0;
    localparam logic REQ_INSERT = 1'b1;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_MOVE
    } t_state;

    typedef struct packed {
        logic do_insert;
        logic do_match;
        logic do_move;
    } t_dp_cmd;

    typedef struct packed {
        logic [CNT_W-1:0] fill;
    } t_dp_stat;

endpackage

`default_nettype wire

/* sv/lkv_ctrl.sv */
// request sequencer: accepts transfers, issues datapath commands,
// owns the result valid flag; depends on lkv_pkg
`timescale 1ns / 1ps
`default_nettype none

module lkv_ctrl
    import lkv_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_req_valid,
    input  wire logic    i_req_type,
    output logic         o_req_stall,
    output logic         o_rsp_valid,
    input  wire logic    i_rsp_stall,
    output t_dp_cmd      o_cmd
);

    t_state r_state, n_state;
    logic   r_rsp_valid, n_rsp_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_rsp_valid = r_rsp_valid && i_rsp_stall;
        o_cmd       = '0;
        o_req_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_req_stall = !i_rst_n;
                if (i_req_valid && i_rst_n) begin
                    if (i_req_type == REQ_INSERT) begin
                        o_cmd.do_insert = 1'b1;
                    end else begin
                        o_cmd.do_match = 1'b1;
                        n_state        = ST_MOVE;
                    end
                end
            end
            ST_MOVE: begin
                // result register must be empty or draining this cycle
                if (!r_rsp_valid || !i_rsp_stall) begin
                    o_cmd.do_move = 1'b1;
                    n_rsp_valid   = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_rsp_valid = r_rsp_valid;

endmodule

`default_nettype wire

/* sv/lkv_datapath.sv */
// entry storage in recency order, parallel key compare, move-to-front
// shifter and result registers; depends on lkv_pkg
`timescale 1ns / 1ps
`default_nettype none

module lkv_datapath
    import lkv_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_dp_cmd               i_cmd,
    input  wire logic [CNT_W-1:0]      i_eff_cap,
    input  wire logic [DATA_WIDTH-1:0] i_key,
    input  wire logic [DATA_WIDTH-1:0] i_value,
    output logic                       o_hit,
    output logic [DATA_WIDTH-1:0]      o_read_value,
    output t_dp_stat                   o_stat
);

    logic [DATA_WIDTH-1:0] r_key   [DEPTH];
    logic [DATA_WIDTH-1:0] r_value [DEPTH];
    logic [DATA_WIDTH-1:0] n_key   [DEPTH];
    logic [DATA_WIDTH-1:0] n_value [DEPTH];
    logic [CNT_W-1:0]      r_count, n_count;
    logic [DEPTH-1:0]      r_match, n_match;
    logic                  r_hit;
    logic [DATA_WIDTH-1:0] r_read_value;

    logic [DEPTH-1:0]      first;
    logic [DEPTH-1:0]      upto;
    logic                  found;
    logic [DATA_WIDTH-1:0] sel_key;
    logic [DATA_WIDTH-1:0] sel_value;
    logic [CNT_W-1:0]      keep;

    always_comb begin
        logic acc;
        acc       = 1'b0;
        n_match   = r_match;
        found     = |r_match;
        // isolate the match nearest the front
        first     = r_match & (~r_match + DEPTH'(1));
        sel_key   = '0;
        sel_value = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (first[i]) begin
                sel_key   = sel_key | r_key[i];
                sel_value = sel_value | r_value[i];
            end
            // positions at or in front of the hit
            upto[i] = found && !acc;
            acc     = acc | first[i];
        end

        if (i_cmd.do_match) begin
            for (int i = 0; i < DEPTH; i++) begin
                n_match[i] = (CNT_W'(i) < r_count) && (r_key[i] == i_key);
            end
        end

        keep    = (r_count >= i_eff_cap) ? (i_eff_cap - CNT_W'(1)) : r_count;
        n_count = r_count;
        n_key   = r_key;
        n_value = r_value;
        if (i_cmd.do_insert) begin
            // entries past the kept fill drop out of the count
            for (int i = 1; i < DEPTH; i++) begin
                n_key[i]   = r_key[i-1];
                n_value[i] = r_value[i-1];
            end
            n_key[0]   = i_key;
            n_value[0] = i_value;
            n_count    = keep + CNT_W'(1);
        end else if (i_cmd.do_move && found) begin
            for (int i = 1; i < DEPTH; i++) begin
                if (upto[i]) begin
                    n_key[i]   = r_key[i-1];
                    n_value[i] = r_value[i-1];
                end
            end
            n_key[0]   = sel_key;
            n_value[0] = sel_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key   <= n_key;
        r_value <= n_value;
        r_match <= n_match;
        if (i_cmd.do_move) begin
            r_hit        <= found;
            r_read_value <= found ? sel_value : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_hit        = r_hit;
    assign o_read_value = r_read_value;
    assign o_stat.fill  = r_count;

endmodule

`default_nettype wire

/* sv/lru_key_value_cache.sv */
// lru key-value cache, most recent entry at the front
// insert: accepted while idle, no result; lookup: key compare registered, then
// move-to-front into the result register, which a stalled result can hold off
// sustained: one insert per cycle while idle; lookups stall requests until moved
// reset: synchronous, store empty, capacity_in_use back to 16; entries uncleared
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module lru_key_value_cache
    import lkv_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_req_valid,
    output logic                       o_req_stall,
    input  wire logic                  i_req_type,
    input  wire logic [DATA_WIDTH-1:0] i_req_key,
    input  wire logic [DATA_WIDTH-1:0] i_req_value,
    output logic                       o_rsp_valid,
    input  wire logic                  i_rsp_stall,
    output logic                       o_hit,
    output logic [DATA_WIDTH-1:0]      o_read_value,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [ADDR_W-1:0]     paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    logic [CAP_W-1:0] r_capacity;
    logic [CNT_W-1:0] eff_cap;
    t_dp_cmd          cmd;
    t_dp_stat         stat;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (psel && penable && pwrite && paddr == ADDR_CAPACITY) begin
            r_capacity <= pwdata[CAP_W-1:0];
        end
    end

    assign prdata = (paddr == ADDR_CAPACITY) ? 32'(r_capacity) : '0;

    // zero behaves as one, anything past the store size as the store size
    always_comb begin
        if (r_capacity == '0) begin
            eff_cap = CNT_W'(1);
        end else if (32'(r_capacity) > 32'(DEPTH)) begin
            eff_cap = CNT_W'(DEPTH);
        end else begin
            eff_cap = CNT_W'(r_capacity);
        end
    end

    lkv_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .i_req_type  (i_req_type),
        .o_req_stall (o_req_stall),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_stall (i_rsp_stall),
        .o_cmd       (cmd)
    );

    lkv_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_eff_cap    (eff_cap),
        .i_key        (i_req_key),
        .i_value      (i_req_value),
        .o_hit        (o_hit),
        .o_read_value (o_read_value),
        .o_stat       (stat)
    );

    `ASSERT_ALWAYS(a_fill_bound, 32'(stat.fill) <= 32'(DEPTH), "fill above store depth")
    `ASSERT_NEXT(a_insert_fill, cmd.do_insert, stat.fill != '0, "insert left store empty")
    `ASSERT_IMPLY(a_miss_zero, o_rsp_valid && !o_hit, o_read_value == '0, "miss with nonzero value")
    `ASSERT_IMPLY(a_one_cmd, cmd.do_insert || cmd.do_match, o_req_stall == 1'b0, "command while stalled")

endmodule

`default_nettype wire
